[design/pfh_pkg.sv]
//------------------------------------------------------------------------------
// pfh_pkg
// Shared constants and types for the planar pose-from-homography unit.
//------------------------------------------------------------------------------
`default_nettype none
package pfh_pkg;

	localparam int FOCAL_W = 31;
	localparam int FIELD_W = 32;
	localparam int N_H     = 9;
	localparam int N_OUT   = 12;

	// Configuration register indexes
	localparam logic [0:0] REG_FOCAL_X = 1'b0;
	localparam logic [0:0] REG_FOCAL_Y = 1'b1;

	typedef logic [FIELD_W-1:0] field_t;

endpackage
`default_nettype wire

[design/pose_from_homography_unit.sv]
//------------------------------------------------------------------------------
// pose_from_homography_unit
// Camera rotation and translation from one tag homography, Q16.16.
//------------------------------------------------------------------------------
// A homography word may be started on every cycle; busy stays low. Each word
// yields one result word, marked by done for one cycle. The path runs through
// the focal divide (64 stages), two 32-stage square roots in series (column
// norms, then scale), the final scale divide (64 stages) and eight register
// stages around them. Results must be taken when shown. Focal lengths are
// to be changed by the user only while no word is in flight; the block does
// not enforce this.
`default_nettype none
module pose_from_homography_unit import pfh_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic signed [31:0]  h00, h01, h02, h10, h11, h12, h20, h21, h22,
	output logic                     done,
	output logic signed [31:0]       rot_ax, rot_ay, rot_az,
	output logic signed [31:0]       rot_bx, rot_by, rot_bz,
	output logic signed [31:0]       rot_cx, rot_cy, rot_cz,
	output logic signed [31:0]       trans_x, trans_y, trans_z,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [0:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);

	localparam logic [63:0] LIM = 64'h7FFF_FFFF;

	logic [FOCAL_W-1:0] focal_x_q, focal_y_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= 31'd65536000;
			focal_y_q <= 31'd65536000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FOCAL_X: focal_x_q <= cfg_data[FOCAL_W-1:0];
				REG_FOCAL_Y: focal_y_q <= cfg_data[FOCAL_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: magnitudes and signs
	field_t h_in [N_H];
	assign h_in = '{h00, h01, h02, h10, h11, h12, h20, h21, h22};
	logic [32:0] mag_s1 [N_H];
	logic [N_H-1:0] neg_s1;
	logic v_s1, zf_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start && !busy;
	end
	always_ff @(posedge clk) begin
		zf_s1 <= (focal_x_q == '0) || (focal_y_q == '0);
		for (int i = 0; i < N_H; i++) begin
			neg_s1[i] <= h_in[i][31];
			mag_s1[i] <= h_in[i][31] ? 33'(-{1'b1, h_in[i]}) : {1'b0, h_in[i]};
		end
	end

	// Focal divides on six elements; rows 2 and signs ride the tag
	localparam int TG = 3*33 + N_H + 1;
	logic [TG-1:0] tg_in, tg_out [6];
	logic [63:0] pq [6];
	logic dv [6];
	assign tg_in = {mag_s1[6], mag_s1[7], mag_s1[8], neg_s1, zf_s1};
	for (genvar i = 0; i < 6; i++) begin : g_fd
		pfh_divu #(.NW(64), .DW(31), .TW(TG)) u_div (
			.clk, .arst_n, .in_vld(v_s1),
			.num(64'({31'd0, mag_s1[i]}) << FRAC_BITS),
			.den(i < 3 ? focal_x_q : focal_y_q),
			.tag_in(tg_in), .out_vld(dv[i]), .quo(pq[i]), .tag_out(tg_out[i])
		);
	end

	// Stage 2: column elements, clamp and square
	logic [63:0] p_s2 [N_H];
	logic [N_H-1:0] neg_s2;
	logic zf_s2, v_s2;
	logic [63:0] sq_s2 [6];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= dv[0];
	end
	always_ff @(posedge clk) begin
		{neg_s2, zf_s2} <= tg_out[0][N_H:0];
		for (int i = 0; i < 6; i++) p_s2[i] <= pq[i];
		p_s2[6] <= 64'(tg_out[0][TG-1 -: 33]);
		p_s2[7] <= 64'(tg_out[0][TG-34 -: 33]);
		p_s2[8] <= 64'(tg_out[0][TG-67 -: 33]);
	end
	function automatic logic [31:0] clamp32(input logic [63:0] v);
		return (v[63:32] != '0) ? 32'hFFFF_FFFF : v[31:0];
	endfunction
	logic v_s3;
	logic [63:0] p_s3 [N_H];
	logic [N_H-1:0] neg_s3;
	logic zf_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	// col a: 0,3,6  col b: 1,4,7
	always_ff @(posedge clk) begin
		sq_s2[0] <= clamp32(p_s2[0]) * clamp32(p_s2[0]);
		sq_s2[1] <= clamp32(p_s2[3]) * clamp32(p_s2[3]);
		sq_s2[2] <= clamp32(p_s2[6]) * clamp32(p_s2[6]);
		sq_s2[3] <= clamp32(p_s2[1]) * clamp32(p_s2[1]);
		sq_s2[4] <= clamp32(p_s2[4]) * clamp32(p_s2[4]);
		sq_s2[5] <= clamp32(p_s2[7]) * clamp32(p_s2[7]);
		p_s3 <= p_s2;
		neg_s3 <= neg_s2;
		zf_s3 <= zf_s2;
	end

	// Stage 4: saturating sums
	function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[64] ? '1 : t[63:0];
	endfunction
	logic v_s4;
	logic [63:0] suma_s4, sumb_s4;
	localparam int TB = 9*64 + N_H + 1;
	logic [TB-1:0] tb_s4, tb_n1, tb_n2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		suma_s4 <= sadd(sadd(sq_s2[0], sq_s2[1]), sq_s2[2]);
		sumb_s4 <= sadd(sadd(sq_s2[3], sq_s2[4]), sq_s2[5]);
		tb_s4 <= {p_s3[0], p_s3[1], p_s3[2], p_s3[3], p_s3[4], p_s3[5],
			p_s3[6], p_s3[7], p_s3[8], neg_s3, zf_s3};
	end

	// Norms
	logic [31:0] na, nb;
	logic vn;
	pfh_sqrt #(.TW(TB)) u_sqa (.clk, .arst_n, .in_vld(v_s4), .val(suma_s4),
		.tag_in(tb_s4), .out_vld(vn), .root(na), .tag_out(tb_n1));
	pfh_sqrt #(.TW(1)) u_sqb (.clk, .arst_n, .in_vld(v_s4), .val(sumb_s4),
		.tag_in(1'b0), .out_vld(), .root(nb), .tag_out());

	// Stage 5: norm product
	logic v_s5;
	logic [63:0] np_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= vn;
	end
	always_ff @(posedge clk) begin
		np_s5 <= na * nb;
		tb_n2 <= tb_n1;
	end

	// Scale
	logic [31:0] sc;
	logic vs;
	logic [TB-1:0] tb_sc;
	pfh_sqrt #(.TW(TB)) u_sqs (.clk, .arst_n, .in_vld(v_s5), .val(np_s5),
		.tag_in(tb_n2), .out_vld(vs), .root(sc), .tag_out(tb_sc));

	// Final divides: nine elements by scale
	logic [63:0] pe [N_H];
	assign {pe[0], pe[1], pe[2], pe[3], pe[4], pe[5], pe[6], pe[7], pe[8]} =
		tb_sc[TB-1:N_H+1];
	localparam int TF = 1 + N_H + N_H + 1;
	logic [TF-1:0] tf_in, tf_out [N_H];
	logic [N_H-1:0] hg;
	logic [63:0] qq [N_H];
	logic dq [N_H];
	for (genvar i = 0; i < N_H; i++) begin : g_hg
		assign hg[i] = pe[i][63:64-FRAC_BITS] != '0;
	end
	assign tf_in = {tb_sc[0] || (sc == '0), hg, tb_sc[N_H:1], 1'b0};
	for (genvar i = 0; i < N_H; i++) begin : g_sd
		pfh_divu #(.NW(64), .DW(32), .TW(TF)) u_div (
			.clk, .arst_n, .in_vld(vs), .num(pe[i] << FRAC_BITS),
			.den((sc == '0) ? 32'd1 : sc), .tag_in(tf_in),
			.out_vld(dq[i]), .quo(qq[i]), .tag_out(tf_out[i])
		);
	end

	function automatic logic signed [31:0] satw(input logic n, input logic [63:0] m);
		if (n) return (m >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-m);
		return (m > LIM) ? 32'sh7FFF_FFFF : m[31:0];
	endfunction

	// Stage 6: saturated rotation and translation
	logic v_s6, z_s6;
	logic signed [31:0] r_s6 [N_H];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= dq[0];
	end
	always_ff @(posedge clk) begin
		z_s6 <= tf_out[0][TF-1];
		for (int i = 0; i < N_H; i++)
			r_s6[i] <= satw(tf_out[0][i+1], tf_out[0][N_H+1+i] ? '1 : qq[i]);
	end
	// r index: 0 a.x 1 b.x 2 t.x 3 a.y 4 b.y 5 t.y 6 a.z 7 b.z 8 t.z

	// Stage 7: cross products
	logic v_s7, z_s7;
	logic signed [63:0] m_s7 [6];
	logic signed [31:0] r_s7 [N_H];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		z_s7 <= z_s6;
		r_s7 <= r_s6;
		m_s7[0] <= r_s6[3] * r_s6[7];
		m_s7[1] <= r_s6[6] * r_s6[4];
		m_s7[2] <= r_s6[6] * r_s6[1];
		m_s7[3] <= r_s6[0] * r_s6[7];
		m_s7[4] <= r_s6[0] * r_s6[4];
		m_s7[5] <= r_s6[1] * r_s6[3];
	end

	function automatic logic signed [31:0] crs(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] d;
		logic [64:0] m;
		d = 65'(a) - 65'(b);
		m = d[64] ? -d : d;
		return satw(d[64], 64'(m >> FRAC_BITS));
	endfunction

	// Stage 8: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_s7;
	end
	always_ff @(posedge clk) begin
		rot_ax <= z_s7 ? '0 : r_s7[0];
		rot_ay <= z_s7 ? '0 : r_s7[3];
		rot_az <= z_s7 ? '0 : r_s7[6];
		rot_bx <= z_s7 ? '0 : r_s7[1];
		rot_by <= z_s7 ? '0 : r_s7[4];
		rot_bz <= z_s7 ? '0 : r_s7[7];
		trans_x <= z_s7 ? '0 : r_s7[2];
		trans_y <= z_s7 ? '0 : r_s7[5];
		trans_z <= z_s7 ? '0 : r_s7[8];
		rot_cx <= z_s7 ? '0 : crs(m_s7[0], m_s7[1]);
		rot_cy <= z_s7 ? '0 : crs(m_s7[2], m_s7[3]);
		rot_cz <= z_s7 ? '0 : crs(m_s7[4], m_s7[5]);
	end

endmodule
`default_nettype wire

[design/pfh_divu.sv]
//------------------------------------------------------------------------------
// pfh_divu
// Pipelined unsigned restoring divider, one quotient bit per stage.
//------------------------------------------------------------------------------
`default_nettype none
module pfh_divu import pfh_pkg::*; #(
	parameter int NW = 64,
	parameter int DW = 64,
	parameter int TW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_vld,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [TW-1:0] tag_in,
	output logic               out_vld,
	output logic [NW-1:0]      quo,
	output logic [TW-1:0]      tag_out
);

	logic [NW-1:0] n_q [NW+1];
	logic [DW:0]   r_q [NW+1];
	logic [DW-1:0] d_q [NW+1];
	logic [TW-1:0] t_q [NW+1];
	logic          v_q [NW+1];

	always_comb begin
		n_q[0] = num;
		r_q[0] = '0;
		d_q[0] = den;
		t_q[0] = tag_in;
		v_q[0] = in_vld;
	end

	// One quotient bit per stage, MSB first
	for (genvar k = 0; k < NW; k++) begin : g_st
		logic [DW+1:0] sh;
		logic [DW+1:0] df;
		always_comb begin
			sh = {r_q[k], n_q[k][NW-1]};
			df = sh - {2'b00, d_q[k]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[k+1] <= 1'b0;
			else v_q[k+1] <= v_q[k];
		end
		always_ff @(posedge clk) begin
			if (!df[DW+1]) begin
				r_q[k+1] <= df[DW:0];
				n_q[k+1] <= {n_q[k][NW-2:0], 1'b1};
			end else begin
				r_q[k+1] <= sh[DW:0];
				n_q[k+1] <= {n_q[k][NW-2:0], 1'b0};
			end
			d_q[k+1] <= d_q[k];
			t_q[k+1] <= t_q[k];
		end
	end

	assign out_vld = v_q[NW];
	assign quo     = n_q[NW];
	assign tag_out = t_q[NW];

endmodule
`default_nettype wire

[design/pfh_sqrt.sv]
//------------------------------------------------------------------------------
// pfh_sqrt
// Pipelined 64-bit integer square root, one root bit per stage.
//------------------------------------------------------------------------------
`default_nettype none
module pfh_sqrt import pfh_pkg::*; #(
	parameter int TW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_vld,
	input  wire logic [63:0]   val,
	input  wire logic [TW-1:0] tag_in,
	output logic               out_vld,
	output logic [31:0]        root,
	output logic [TW-1:0]      tag_out
);

	logic [63:0]   v_q [33];
	logic [33:0]   r_q [33];
	logic [31:0]   q_q [33];
	logic [TW-1:0] t_q [33];
	logic          vl_q [33];

	always_comb begin
		v_q[0] = val;
		r_q[0] = '0;
		q_q[0] = '0;
		t_q[0] = tag_in;
		vl_q[0] = in_vld;
	end

	// Digit-by-digit root: bring down two bits, try 4q+1
	for (genvar k = 0; k < 32; k++) begin : g_st
		logic [35:0] rem;
		logic [35:0] trial;
		logic [35:0] df;
		always_comb begin
			rem   = {r_q[k], v_q[k][63:62]};
			trial = {2'b00, q_q[k], 2'b01};
			df    = rem - trial;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vl_q[k+1] <= 1'b0;
			else vl_q[k+1] <= vl_q[k];
		end
		always_ff @(posedge clk) begin
			v_q[k+1] <= {v_q[k][61:0], 2'b00};
			t_q[k+1] <= t_q[k];
			if (!df[35]) begin
				r_q[k+1] <= df[33:0];
				q_q[k+1] <= {q_q[k][30:0], 1'b1};
			end else begin
				r_q[k+1] <= rem[33:0];
				q_q[k+1] <= {q_q[k][30:0], 1'b0};
			end
		end
	end

	assign out_vld = vl_q[32];
	assign root    = q_q[32];
	assign tag_out = t_q[32];

endmodule
`default_nettype wire

[design/pfh_checker.sv]
//------------------------------------------------------------------------------
// pfh_checker
// Port-level checks for the pose unit.
//------------------------------------------------------------------------------
`default_nettype none
module pfh_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic busy,
	input wire logic done,
	input wire logic cfg_ready,
	input wire logic start
);
	a_nobusy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("cfg stalled");
	a_rst: assert property (@(posedge clk) !arst_n |=> !done)
		else $error("done after reset");
	// Every word taken shows its result on done
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##200 done)
		else $error("result word missing at fixed latency");
endmodule

bind pose_from_homography_unit pfh_checker u_chk (.clk, .arst_n, .busy, .done,
	.cfg_ready, .start);
`default_nettype wire

[tb/tb_pose_from_homography_unit.sv]
//------------------------------------------------------------------------------
// tb_pose_from_homography_unit
// Self-checking bench for the planar pose-from-homography unit: directed
// and random-burst homography words are driven, a scoreboard predicts each
// pose word and checks it field by field with what the unit shows on done.
//------------------------------------------------------------------------------
`default_nettype none
module tb_pose_from_homography_unit;
	import pfh_pkg::*;

	localparam int FRAC          = 16;
	localparam int DRAIN_CYCLES  = 300;
	localparam int WATCHDOG_MAX  = 5000;

	typedef struct {
		field_t h [N_H];
	} homog_t;

	typedef struct {
		field_t f [N_OUT];
	} pose_t;

	// Scoreboard: focal lengths, pose predictor and the queue of pending poses
	class pose_scoreboard;
		longint unsigned focal_x_q;
		longint unsigned focal_y_q;
		pose_t pending [$];
		int mismatches;
		int checked;

		function new();
			focal_x_q = 64'd65536000;
			focal_y_q = 64'd65536000;
			mismatches = 0;
			checked = 0;
		endfunction

		function void set_focal(logic [0:0] idx, logic [31:0] data);
			if (idx == REG_FOCAL_X)
				focal_x_q = {33'd0, data[30:0]};
			else
				focal_y_q = {33'd0, data[30:0]};
		endfunction

		static function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		static function field_t sat32(bit neg, longint unsigned mag);
			longint unsigned lim;
			lim = 64'd1 << 31;
			if (neg)
				return (mag >= lim) ? 32'h8000_0000 : field_t'(-mag);
			return (mag >= lim) ? 32'h7FFF_FFFF : field_t'(mag);
		endfunction

		static function longint unsigned col_norm(longint unsigned p0, longint unsigned p1,
				longint unsigned p2);
			longint unsigned c [3];
			longint unsigned sum;
			longint unsigned sq;
			c[0] = p0;
			c[1] = p1;
			c[2] = p2;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				if (c[i] > 64'hFFFF_FFFF)
					c[i] = 64'hFFFF_FFFF;
				sq = c[i] * c[i];
				sum = (sum > ~sq) ? 64'hFFFF_FFFF_FFFF_FFFF : sum + sq;
			end
			return int_sqrt(sum);
		endfunction

		static function field_t scale_elem(bit neg, longint unsigned p, longint unsigned s);
			if (p > (64'hFFFF_FFFF_FFFF_FFFF >> FRAC))
				return sat32(neg, 64'hFFFF_FFFF_FFFF_FFFF);
			return sat32(neg, (p << FRAC) / s);
		endfunction

		static function field_t cross_elem(field_t u, field_t v, field_t w, field_t z);
			longint d;
			longint unsigned m;
			d = longint'($signed(u)) * longint'($signed(v))
				- longint'($signed(w)) * longint'($signed(z));
			m = (d < 0) ? longint'(-d) : d;
			return sat32(d < 0, m >> FRAC);
		endfunction

		function pose_t pose_of(homog_t hw);
			pose_t r;
			longint unsigned p [N_H];
			bit neg [N_H];
			longint v;
			longint unsigned s;
			for (int i = 0; i < N_OUT; i++)
				r.f[i] = '0;
			for (int i = 0; i < N_H; i++) begin
				v = longint'($signed(hw.h[i]));
				neg[i] = v < 0;
				p[i] = neg[i] ? longint'(-v) : v;
			end
			if (focal_x_q == 0 || focal_y_q == 0)
				return r;
			for (int i = 0; i < 3; i++) begin
				p[i] = (p[i] << FRAC) / focal_x_q;
				p[3 + i] = (p[3 + i] << FRAC) / focal_y_q;
			end
			s = int_sqrt(col_norm(p[0], p[3], p[6]) * col_norm(p[1], p[4], p[7]));
			if (s == 0)
				return r;
			for (int i = 0; i < 3; i++) begin
				r.f[i]     = scale_elem(neg[3 * i], p[3 * i], s);
				r.f[3 + i] = scale_elem(neg[3 * i + 1], p[3 * i + 1], s);
				r.f[9 + i] = scale_elem(neg[3 * i + 2], p[3 * i + 2], s);
			end
			r.f[6] = cross_elem(r.f[1], r.f[5], r.f[4], r.f[2]);
			r.f[7] = cross_elem(r.f[3], r.f[2], r.f[0], r.f[5]);
			r.f[8] = cross_elem(r.f[0], r.f[4], r.f[3], r.f[1]);
			return r;
		endfunction

		function void note_homography(homog_t hw);
			pending.push_back(pose_of(hw));
		endfunction

		function void check_pose(pose_t got);
			pose_t want;
			bit bad;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: pose word with nothing pending");
				return;
			end
			want = pending.pop_front();
			bad = 0;
			for (int i = 0; i < N_OUT; i++)
				if (got.f[i] !== want.f[i]) begin
					bad = 1;
					if (mismatches < 10)
						$display("ERROR: pose field %0d expected %h got %h", i,
							want.f[i], got.f[i]);
				end
			if (bad)
				mismatches++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] h00 = '0, h01 = '0, h02 = '0, h10 = '0, h11 = '0, h12 = '0;
	logic signed [31:0] h20 = '0, h21 = '0, h22 = '0;
	logic done;
	logic signed [31:0] rot_ax, rot_ay, rot_az, rot_bx, rot_by, rot_bz;
	logic signed [31:0] rot_cx, rot_cy, rot_cz, trans_x, trans_y, trans_z;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	pose_scoreboard sb = new();
	int idle_cycles = 0;
	int words_sent = 0;
	int cfg_writes = 0;

	always #5 clk = ~clk;

	pose_from_homography_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.h00(h00), .h01(h01), .h02(h02), .h10(h10), .h11(h11), .h12(h12),
		.h20(h20), .h21(h21), .h22(h22),
		.done(done),
		.rot_ax(rot_ax), .rot_ay(rot_ay), .rot_az(rot_az),
		.rot_bx(rot_bx), .rot_by(rot_by), .rot_bz(rot_bz),
		.rot_cx(rot_cx), .rot_cy(rot_cy), .rot_cz(rot_cz),
		.trans_x(trans_x), .trans_y(trans_y), .trans_z(trans_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Input monitor: note each homography word taken
	always @(posedge clk) begin
		homog_t hw;
		if (arst_n && start && !busy) begin
			hw.h = '{h00, h01, h02, h10, h11, h12, h20, h21, h22};
			sb.note_homography(hw);
		end
	end

	// Output monitor and watchdog
	always @(posedge clk) begin
		pose_t got;
		if (arst_n && done) begin
			got.f = '{rot_ax, rot_ay, rot_az, rot_bx, rot_by, rot_bz,
				rot_cx, rot_cy, rot_cz, trans_x, trans_y, trans_z};
			sb.check_pose(got);
		end
		if ((arst_n && done) || (arst_n && start && !busy) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_MAX) begin
			$display("ERROR: watchdog expired");
			$display("FAILED: results differ");
			$finish;
		end
	end

	// One homography word; start stays high for back-to-back words
	task automatic send_word(homog_t hw);
		bit b;
		start <= 1'b1;
		h00 <= hw.h[0]; h01 <= hw.h[1]; h02 <= hw.h[2];
		h10 <= hw.h[3]; h11 <= hw.h[4]; h12 <= hw.h[5];
		h20 <= hw.h[6]; h21 <= hw.h[7]; h22 <= hw.h[8];
		do begin
			@(negedge clk);
			b = busy;
			@(posedge clk);
		end while (b);
		words_sent++;
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Let every pending pose arrive, then the pipeline settle
	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_focal(logic [0:0] idx, logic [31:0] data);
		bit r;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(negedge clk);
			r = cfg_ready;
			@(posedge clk);
		end while (!r);
		cfg_valid <= 1'b0;
		sb.set_focal(idx, data);
		cfg_writes++;
	endtask

	function automatic field_t rand_elem();
		field_t v;
		case ($urandom_range(0, 9))
			0: v = $urandom;
			1: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: v = '0;
			default: begin
				// realistic magnitudes: fractions of a pixel to just under 4096 in Q16.16
				v = $urandom >> $urandom_range(4, 20);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic homog_t rand_homog();
		homog_t hw;
		for (int i = 0; i < N_H; i++)
			hw.h[i] = rand_elem();
		return hw;
	endfunction

	function automatic homog_t mk(field_t a, field_t b, field_t c, field_t d, field_t e,
			field_t f, field_t g, field_t i, field_t j);
		homog_t hw;
		hw.h = '{a, b, c, d, e, f, g, i, j};
		return hw;
	endfunction

	// Random words in bursts with gaps; one full drain partway through
	task automatic random_burst(int n);
		int left;
		int burst;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 20);
			for (int k = 0; k < burst && left > 0; k++) begin
				send_word(rand_homog());
				left--;
				if (left == n / 2)
					drain();
			end
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 8));
		end
		start <= 1'b0;
	endtask

	initial begin
		localparam field_t ONE = 32'h0001_0000;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed words at reset focal lengths
		send_word(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(mk(ONE * 1000, 0, 0, 0, ONE * 1000, 0, 0, 0, ONE));
		send_word(mk(ONE * 500, -ONE * 20, ONE * 320, ONE * 30, ONE * 480, ONE * 240,
			ONE / 100, -ONE / 50, ONE));
		send_word(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_word(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		// first column zero: zero scale
		send_word(mk(0, ONE, ONE, 0, ONE, ONE, 0, ONE, ONE));
		// second column zero: zero scale
		send_word(mk(ONE, 0, ONE, ONE, 0, ONE, ONE, 0, ONE));
		// tiny values that vanish in the focal divide
		send_word(mk(1, 1, 1, 1, 1, 1, 1, 1, 1));
		send_word(mk(-1, 1, -1, 1, -1, 1, -1, 1, -1));
		// huge translation, but the first column vanishes in the focal divide: zero scale
		send_word(mk(1, 0, 32'h7FFF_FFFF, 0, 1, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF));
		send_word(mk(0, 0, 0, 0, 0, 0, 1, 1, -1));
		send_word(mk(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0,
			0, 0, 0));
		send_word(mk(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
		random_burst(150);
		drain();

		// Smallest nonzero focal length on x, 1.0 in Q16.16 on y
		write_focal(REG_FOCAL_X, 32'h0000_0001);
		write_focal(REG_FOCAL_Y, 32'h0001_0000);
		send_word(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 1));
		random_burst(100);
		drain();

		// Largest focal lengths; bit 31 of the data must be dropped
		write_focal(REG_FOCAL_X, 32'hFFFF_FFFF);
		write_focal(REG_FOCAL_Y, 32'h7FFF_FFFF);
		random_burst(100);
		drain();

		// Zero focal length on either axis gives all-zero poses
		write_focal(REG_FOCAL_X, 32'h8000_0000);
		random_burst(40);
		drain();
		write_focal(REG_FOCAL_X, 32'd500 << 16);
		write_focal(REG_FOCAL_Y, 32'd0);
		random_burst(40);
		drain();

		// Typical camera
		write_focal(REG_FOCAL_Y, 32'd800 << 16);
		random_burst(300);
		drain();

		$display("Run covered %0d homography words, %0d pose words, %0d focal writes",
			words_sent, sb.checked, cfg_writes);
		$display("Focal settings: reset, minimum, maximum, zero on each axis, typical");
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire
